@@ sv/mkse_pkg.sv @@
// shared types, constants and microcode table for the keypad scanner
package mkse_pkg;

  localparam int MaxRows   = 8;
  localparam int MaxCols   = 8;
  localparam int PortWidth = 16;
  localparam int PinW      = 4;
  localparam int RowW      = $clog2(MaxRows);
  localparam int ColW      = $clog2(MaxCols);
  localparam int KeyW      = 6;
  localparam int TickW     = 17;
  localparam int CfgIdxW   = 3;
  localparam int CfgDataW  = 32;

  localparam logic [15:0] PortMask       = 16'((32'd1 << PortWidth) - 32'd1);
  localparam logic [15:0] ReleasePattern = 16'hFFFF & PortMask;
  localparam logic [15:0] ZeroPattern    = 16'h0000;
  localparam logic [TickW-1:0] TickMax   = {TickW{1'b1}};

  localparam logic [CfgIdxW-1:0] CfgRowPinMap   = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgColPinMap   = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgNumRows     = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgNumCols     = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgScanInterval = 3'd4;

  localparam logic FuncTick   = 1'b0;
  localparam logic KindDrive  = 1'b0;
  localparam logic KindEvent  = 1'b1;

  typedef struct packed {
    logic        func;
    logic [15:0] port_value;
  } in_t;

  typedef struct packed {
    logic            kind;
    logic [15:0]     drive_pattern;
    logic [KeyW-1:0] key_code;
    logic            pressed;
    logic            last;
  } out_t;

  typedef enum logic [1:0] {
    PH_IDLE, PH_CHECK, PH_COL, PH_COMPARE
  } phase_e;

  typedef enum logic [4:0] {
    S_FETCH, S_DISP, S_PDISP, S_PCOL, S_TICK, S_TICK_CHK, S_START, S_CHK,
    S_CLEAR, S_RMASK, S_COL, S_COL_CHK, S_DONE, S_NEXT, S_EINIT, S_ESCAN,
    S_EPUSH, S_ESTEP, S_EFIN
  } step_e;

  typedef enum logic [3:0] {
    OP_NONE, OP_TICK, OP_START_CHECK, OP_CLEAR_MAP, OP_READ_MASK, OP_STORE_COL,
    OP_SCAN_DONE, OP_NEXT_COL, OP_EVT_INIT, OP_EVT_PUSH, OP_K_INC, OP_EVT_FINISH
  } op_e;

  typedef enum logic [1:0] {
    EM_NONE, EM_DRIVE, EM_HOLD
  } emit_e;

  typedef enum logic [1:0] {
    PAT_CHECK, PAT_RELEASE, PAT_COL0, PAT_COLNEXT
  } pat_e;

  typedef enum logic [3:0] {
    C_TRUE, C_COMPARE, C_FUNC0, C_PH_CHECK, C_PH_COL, C_SCAN_GO, C_ALL_HIGH,
    C_LAST_COL, C_KEY_DIFF, C_KEY_END
  } cond_e;

  typedef struct packed {
    logic  wait_in;
    op_e   op;
    emit_e emit;
    pat_e  pat;
    logic  last;
    cond_e cond;
    step_e tgt_t;
    step_e tgt_f;
  } cw_t;

  typedef struct packed {
    logic stall;
    logic compare;
    logic func0;
    logic ph_check;
    logic ph_col;
    logic scan_go;
    logic all_high;
    logic last_col;
    logic key_diff;
    logic key_end;
  } stat_t;

  function automatic cw_t mk(logic w, op_e op, emit_e em, pat_e pat, logic last,
                             cond_e cond, step_e t, step_e f);
    cw_t cw;
    cw.wait_in = w;
    cw.op      = op;
    cw.emit    = em;
    cw.pat     = pat;
    cw.last    = last;
    cw.cond    = cond;
    cw.tgt_t   = t;
    cw.tgt_f   = f;
    return cw;
  endfunction

  function automatic cw_t ucode(step_e s);
    cw_t cw;
    unique case (s)
      S_FETCH:    cw = mk(1'b1, OP_NONE, EM_NONE, PAT_RELEASE, 1'b0, C_COMPARE,
                          S_EINIT, S_DISP);
      S_DISP:     cw = mk(1'b0, OP_NONE, EM_NONE, PAT_RELEASE, 1'b0, C_FUNC0,
                          S_TICK, S_PDISP);
      S_PDISP:    cw = mk(1'b0, OP_NONE, EM_NONE, PAT_RELEASE, 1'b0, C_PH_CHECK,
                          S_CHK, S_PCOL);
      S_PCOL:     cw = mk(1'b0, OP_NONE, EM_NONE, PAT_RELEASE, 1'b0, C_PH_COL,
                          S_COL, S_FETCH);
      S_TICK:     cw = mk(1'b0, OP_TICK, EM_NONE, PAT_RELEASE, 1'b0, C_TRUE,
                          S_TICK_CHK, S_TICK_CHK);
      S_TICK_CHK: cw = mk(1'b0, OP_NONE, EM_NONE, PAT_RELEASE, 1'b0, C_SCAN_GO,
                          S_START, S_FETCH);
      S_START:    cw = mk(1'b0, OP_START_CHECK, EM_DRIVE, PAT_CHECK, 1'b1, C_TRUE,
                          S_FETCH, S_FETCH);
      S_CHK:      cw = mk(1'b0, OP_NONE, EM_NONE, PAT_RELEASE, 1'b0, C_ALL_HIGH,
                          S_CLEAR, S_RMASK);
      S_CLEAR:    cw = mk(1'b0, OP_CLEAR_MAP, EM_DRIVE, PAT_RELEASE, 1'b1, C_TRUE,
                          S_FETCH, S_FETCH);
      S_RMASK:    cw = mk(1'b0, OP_READ_MASK, EM_DRIVE, PAT_COL0, 1'b1, C_TRUE,
                          S_FETCH, S_FETCH);
      S_COL:      cw = mk(1'b0, OP_STORE_COL, EM_NONE, PAT_RELEASE, 1'b0, C_TRUE,
                          S_COL_CHK, S_COL_CHK);
      S_COL_CHK:  cw = mk(1'b0, OP_NONE, EM_NONE, PAT_RELEASE, 1'b0, C_LAST_COL,
                          S_DONE, S_NEXT);
      S_DONE:     cw = mk(1'b0, OP_SCAN_DONE, EM_DRIVE, PAT_RELEASE, 1'b1, C_TRUE,
                          S_FETCH, S_FETCH);
      S_NEXT:     cw = mk(1'b0, OP_NEXT_COL, EM_DRIVE, PAT_COLNEXT, 1'b1, C_TRUE,
                          S_FETCH, S_FETCH);
      S_EINIT:    cw = mk(1'b0, OP_EVT_INIT, EM_NONE, PAT_RELEASE, 1'b0, C_TRUE,
                          S_ESCAN, S_ESCAN);
      S_ESCAN:    cw = mk(1'b0, OP_NONE, EM_NONE, PAT_RELEASE, 1'b0, C_KEY_DIFF,
                          S_EPUSH, S_ESTEP);
      S_EPUSH:    cw = mk(1'b0, OP_EVT_PUSH, EM_HOLD, PAT_RELEASE, 1'b0, C_TRUE,
                          S_ESTEP, S_ESTEP);
      S_ESTEP:    cw = mk(1'b0, OP_K_INC, EM_NONE, PAT_RELEASE, 1'b0, C_KEY_END,
                          S_EFIN, S_ESCAN);
      S_EFIN:     cw = mk(1'b0, OP_EVT_FINISH, EM_HOLD, PAT_RELEASE, 1'b1, C_TRUE,
                          S_FETCH, S_FETCH);
      default:    cw = mk(1'b0, OP_NONE, EM_NONE, PAT_RELEASE, 1'b0, C_TRUE,
                          S_FETCH, S_FETCH);
    endcase
    return cw;
  endfunction

endpackage

@@ sv/matrix_keypad_scanner_events.sv @@
// top level: keypad scanner datapath, registers and handshakes
// Matrix keypad scanner with key change events. Items are taken one at a time
// by a microcoded sequencer that runs a short control program per item. The
// item after a completed scan walks all 64 key positions of the map, with an
// extra step for each changed key.
// Each result goes through a single output register, so a stalled consumer
// holds the sequencer on the step that emits. Configuration writes are taken
// at any time through the plain write port.
module matrix_keypad_scanner_events_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  mkse_pkg::in_t                 in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output mkse_pkg::out_t                out_data_o,
  input  logic                          cfg_we_i,
  input  logic [mkse_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [mkse_pkg::CfgDataW-1:0] cfg_wdata_i
);

  localparam int RW = mkse_pkg::RowW;
  localparam int CW = mkse_pkg::ColW;

  logic [31:0] row_map_q, col_map_q;
  logic [3:0]  num_rows_q, num_cols_q;
  logic [15:0] interval_q;

  mkse_pkg::phase_e            phase_q, phase_d;
  logic [CW-1:0]               col_q, col_d;
  logic [15:0]                 rmask_q, rmask_d;
  logic [mkse_pkg::TickW-1:0]  tick_q, tick_d;
  logic [mkse_pkg::MaxCols-1:0] cur_q [mkse_pkg::MaxRows];
  logic [mkse_pkg::MaxCols-1:0] cur_d [mkse_pkg::MaxRows];
  logic [mkse_pkg::MaxCols-1:0] prev_q [mkse_pkg::MaxRows];
  logic [mkse_pkg::MaxCols-1:0] prev_d [mkse_pkg::MaxRows];
  logic                        func_q;
  logic [15:0]                 port_q;
  logic [mkse_pkg::KeyW-1:0]   k_q, k_d;
  logic [mkse_pkg::KeyW-1:0]   hold_code_q, hold_code_d;
  logic                        hold_pr_q, hold_pr_d;
  logic                        hold_vld_q, hold_vld_d;
  mkse_pkg::out_t              out_q, out_d, emit_data;
  logic                        out_vld_q, out_vld_d;

  mkse_pkg::cw_t   cw;
  mkse_pkg::stat_t stat;

  logic [3:0]    rows_u, cols_u;
  logic [15:0]   check_mask, colread, pattern;
  logic [RW-1:0] kr;
  logic [CW-1:0] kc, col_nx;
  logic          emit_need, stall, go, accept;
  logic [6:0]    code_w;

  function automatic logic [3:0] clamp_size(logic [3:0] n, logic [3:0] max_n);
    logic [3:0] v;
    v = n;
    if (v == 4'd0) v = 4'd1;
    if (v > max_n) v = max_n;
    return v;
  endfunction

  function automatic logic [15:0] col_pattern(logic [31:0] map, logic [CW-1:0] c);
    logic [3:0]  pin;
    logic [15:0] pat;
    pin = map[{c, 2'b00} +: mkse_pkg::PinW];
    pat = mkse_pkg::ReleasePattern;
    if ({1'b0, pin} < 5'(mkse_pkg::PortWidth)) pat[pin] = 1'b0;
    return pat & mkse_pkg::PortMask;
  endfunction

  mkse_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .cw_o   (cw)
  );

  assign rows_u = clamp_size(num_rows_q, 4'(mkse_pkg::MaxRows));
  assign cols_u = clamp_size(num_cols_q, 4'(mkse_pkg::MaxCols));

  always_comb begin
    logic [3:0] pin;
    check_mask = mkse_pkg::ZeroPattern;
    for (int r = 0; r < mkse_pkg::MaxRows; r++) begin
      pin = row_map_q[r*mkse_pkg::PinW +: mkse_pkg::PinW];
      if (4'(r) < rows_u && {1'b0, pin} < 5'(mkse_pkg::PortWidth)) begin
        check_mask[pin] = 1'b1;
      end
    end
    check_mask = check_mask & mkse_pkg::PortMask;
  end

  assign colread = ~port_q & rmask_q & mkse_pkg::PortMask;
  assign col_nx  = col_q + CW'(1);
  assign kr      = k_q[CW +: RW];
  assign kc      = k_q[CW-1:0];
  assign code_w  = 7'(kr) * 7'(cols_u) + 7'(kc);

  always_comb begin
    unique case (cw.pat)
      mkse_pkg::PAT_CHECK:   pattern = check_mask;
      mkse_pkg::PAT_RELEASE: pattern = mkse_pkg::ReleasePattern;
      mkse_pkg::PAT_COL0:    pattern = col_pattern(col_map_q, '0);
      mkse_pkg::PAT_COLNEXT: pattern = col_pattern(col_map_q, col_nx);
      default:               pattern = mkse_pkg::ReleasePattern;
    endcase
  end

  always_comb begin
    emit_data = '0;
    if (cw.emit == mkse_pkg::EM_HOLD) begin
      emit_data.kind     = mkse_pkg::KindEvent;
      emit_data.key_code = hold_code_q;
      emit_data.pressed  = hold_pr_q;
      emit_data.last     = cw.last;
    end else begin
      emit_data.kind          = mkse_pkg::KindDrive;
      emit_data.drive_pattern = pattern;
      emit_data.last          = cw.last;
    end
  end

  assign emit_need = (cw.emit == mkse_pkg::EM_DRIVE) ||
                     (cw.emit == mkse_pkg::EM_HOLD && hold_vld_q);
  assign stall     = (cw.wait_in && !in_valid_i) ||
                     (emit_need && out_vld_q && !out_ready_i);
  assign go        = !stall;
  assign in_ready_o = cw.wait_in;
  assign accept    = in_valid_i && cw.wait_in;

  always_comb begin
    stat.stall    = stall;
    stat.compare  = (phase_q == mkse_pkg::PH_COMPARE);
    stat.func0    = (func_q == mkse_pkg::FuncTick);
    stat.ph_check = (phase_q == mkse_pkg::PH_CHECK);
    stat.ph_col   = (phase_q == mkse_pkg::PH_COL);
    stat.scan_go  = (phase_q == mkse_pkg::PH_IDLE) && (tick_q > {1'b0, interval_q});
    stat.all_high = ((port_q & check_mask) == check_mask);
    stat.last_col = ({1'b0, col_q} + 4'd1) >= cols_u;
    stat.key_diff = cur_q[kr][kc] ^ prev_q[kr][kc] &&
                    ({1'b0, kr} < rows_u) && ({1'b0, kc} < cols_u);
    stat.key_end  = (k_q == {mkse_pkg::KeyW{1'b1}});
  end

  always_comb begin
    logic [3:0] pin;
    pin         = '0;
    phase_d     = phase_q;
    col_d       = col_q;
    rmask_d     = rmask_q;
    tick_d      = tick_q;
    cur_d       = cur_q;
    prev_d      = prev_q;
    k_d         = k_q;
    hold_code_d = hold_code_q;
    hold_pr_d   = hold_pr_q;
    hold_vld_d  = hold_vld_q;
    if (go) begin
      unique case (cw.op)
        mkse_pkg::OP_NONE: begin
        end
        mkse_pkg::OP_TICK: begin
          if (tick_q != mkse_pkg::TickMax) tick_d = tick_q + 1'b1;
        end
        mkse_pkg::OP_START_CHECK: begin
          phase_d = mkse_pkg::PH_CHECK;
        end
        mkse_pkg::OP_CLEAR_MAP: begin
          for (int r = 0; r < mkse_pkg::MaxRows; r++) begin
            if (4'(r) < rows_u) cur_d[r] = '0;
          end
          phase_d = mkse_pkg::PH_COMPARE;
        end
        mkse_pkg::OP_READ_MASK: begin
          rmask_d = ~port_q & check_mask & mkse_pkg::PortMask;
          col_d   = '0;
          phase_d = mkse_pkg::PH_COL;
        end
        mkse_pkg::OP_STORE_COL: begin
          for (int r = 0; r < mkse_pkg::MaxRows; r++) begin
            pin = row_map_q[r*mkse_pkg::PinW +: mkse_pkg::PinW];
            if (4'(r) < rows_u) begin
              cur_d[r][col_q] = ({1'b0, pin} < 5'(mkse_pkg::PortWidth)) ?
                                colread[pin] : 1'b0;
            end
          end
        end
        mkse_pkg::OP_SCAN_DONE: begin
          col_d   = '0;
          phase_d = mkse_pkg::PH_COMPARE;
        end
        mkse_pkg::OP_NEXT_COL: begin
          col_d = col_nx;
        end
        mkse_pkg::OP_EVT_INIT: begin
          k_d        = '0;
          hold_vld_d = 1'b0;
        end
        mkse_pkg::OP_EVT_PUSH: begin
          hold_code_d = code_w[mkse_pkg::KeyW-1:0];
          hold_pr_d   = cur_q[kr][kc];
          hold_vld_d  = 1'b1;
        end
        mkse_pkg::OP_K_INC: begin
          k_d = k_q + 1'b1;
        end
        mkse_pkg::OP_EVT_FINISH: begin
          for (int r = 0; r < mkse_pkg::MaxRows; r++) begin
            if (4'(r) < rows_u) prev_d[r] = cur_q[r];
          end
          tick_d     = '0;
          phase_d    = mkse_pkg::PH_IDLE;
          hold_vld_d = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    out_d     = out_q;
    out_vld_d = out_vld_q;
    if (emit_need && go) begin
      out_d     = emit_data;
      out_vld_d = 1'b1;
    end else if (out_ready_i) begin
      out_vld_d = 1'b0;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_map_q  <= 32'd1985229328;
      col_map_q  <= 32'd4275878552;
      num_rows_q <= 4'd4;
      num_cols_q <= 4'd4;
      interval_q <= 16'd10;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        mkse_pkg::CfgRowPinMap:    row_map_q  <= cfg_wdata_i;
        mkse_pkg::CfgColPinMap:    col_map_q  <= cfg_wdata_i;
        mkse_pkg::CfgNumRows:      num_rows_q <= cfg_wdata_i[3:0];
        mkse_pkg::CfgNumCols:      num_cols_q <= cfg_wdata_i[3:0];
        mkse_pkg::CfgScanInterval: interval_q <= cfg_wdata_i[15:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= mkse_pkg::PH_IDLE;
      col_q      <= '0;
      rmask_q    <= '0;
      tick_q     <= '0;
      k_q        <= '0;
      hold_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
      for (int r = 0; r < mkse_pkg::MaxRows; r++) begin
        cur_q[r]  <= '0;
        prev_q[r] <= '0;
      end
    end else begin
      phase_q    <= phase_d;
      col_q      <= col_d;
      rmask_q    <= rmask_d;
      tick_q     <= tick_d;
      k_q        <= k_d;
      hold_vld_q <= hold_vld_d;
      out_vld_q  <= out_vld_d;
      cur_q      <= cur_d;
      prev_q     <= prev_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q <= in_data_i.func;
      port_q <= in_data_i.port_value & mkse_pkg::PortMask;
    end
    hold_code_q <= hold_code_d;
    hold_pr_q   <= hold_pr_d;
    out_q       <= out_d;
  end

endmodule

@@ sv/mkse_seq.sv @@
// microcode sequencer: step counter, control rom and conditional jumps
module mkse_seq (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  mkse_pkg::stat_t stat_i,
  output mkse_pkg::cw_t   cw_o
);

  mkse_pkg::step_e step_q, step_d;
  mkse_pkg::cw_t   cw;
  logic            taken;

  assign cw   = mkse_pkg::ucode(step_q);
  assign cw_o = cw;

  always_comb begin
    unique case (cw.cond)
      mkse_pkg::C_TRUE:     taken = 1'b1;
      mkse_pkg::C_COMPARE:  taken = stat_i.compare;
      mkse_pkg::C_FUNC0:    taken = stat_i.func0;
      mkse_pkg::C_PH_CHECK: taken = stat_i.ph_check;
      mkse_pkg::C_PH_COL:   taken = stat_i.ph_col;
      mkse_pkg::C_SCAN_GO:  taken = stat_i.scan_go;
      mkse_pkg::C_ALL_HIGH: taken = stat_i.all_high;
      mkse_pkg::C_LAST_COL: taken = stat_i.last_col;
      mkse_pkg::C_KEY_DIFF: taken = stat_i.key_diff;
      mkse_pkg::C_KEY_END:  taken = stat_i.key_end;
      default:              taken = 1'b1;
    endcase
  end

  always_comb begin
    if (stat_i.stall) begin
      step_d = step_q;
    end else if (taken) begin
      step_d = cw.tgt_t;
    end else begin
      step_d = cw.tgt_f;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= mkse_pkg::S_FETCH;
    end else begin
      step_q <= step_d;
    end
  end

endmodule

@@ dv/mkse_scan_checker.sv @@
// keypad scanner checker: tracks scanner state, predicts drive patterns and key events
`timescale 1ns / 100ps

module mkse_scan_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  input  logic                           in_ready_i,
  input  mkse_pkg::in_t                  in_data_i,
  input  logic                           out_valid_i,
  input  logic                           out_ready_i,
  input  mkse_pkg::out_t                 out_data_i,
  input  logic                           cfg_we_i,
  input  logic [mkse_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [mkse_pkg::CfgDataW-1:0]  cfg_wdata_i,
  output int                             pending_o,
  output int                             fail_count_o
);

  localparam logic [31:0] RowPinsReset = 32'h7654_3210;
  localparam logic [31:0] ColPinsReset = 32'hFEDC_BA98;

  logic [31:0]      row_pins;
  logic [31:0]      col_pins;
  logic [3:0]       rows_cfg;
  logic [3:0]       cols_cfg;
  logic [15:0]      interval;

  mkse_pkg::phase_e           ph;
  logic [2:0]                 col_at;
  logic [15:0]                row_sel;
  logic [mkse_pkg::TickW-1:0] ticks;
  logic [7:0]                 key_now  [mkse_pkg::MaxRows];
  logic [7:0]                 key_seen [mkse_pkg::MaxRows];

  mkse_pkg::out_t   scan_output_q[$];
  int               errors;

  function automatic int rows_active();
    int n;
    n = int'(rows_cfg);
    if (n == 0) n = 1;
    if (n > mkse_pkg::MaxRows) n = mkse_pkg::MaxRows;
    return n;
  endfunction

  function automatic int cols_active();
    int n;
    n = int'(cols_cfg);
    if (n == 0) n = 1;
    if (n > mkse_pkg::MaxCols) n = mkse_pkg::MaxCols;
    return n;
  endfunction

  function automatic logic [15:0] check_pattern();
    logic [15:0] m;
    int p;
    m = '0;
    for (int r = 0; r < rows_active(); r++) begin
      p = int'(row_pins[4*r +: 4]);
      if (p < mkse_pkg::PortWidth) m[p] = 1'b1;
    end
    return m & mkse_pkg::PortMask;
  endfunction

  function automatic logic [15:0] col_pattern(input logic [2:0] c);
    logic [15:0] pat;
    int p;
    pat = mkse_pkg::ReleasePattern;
    p = int'(col_pins[4*c +: 4]);
    if (p < mkse_pkg::PortWidth) pat[p] = 1'b0;
    return pat & mkse_pkg::PortMask;
  endfunction

  function automatic mkse_pkg::out_t drive_result(input logic [15:0] pat);
    mkse_pkg::out_t res;
    res = '0;
    res.kind = mkse_pkg::KindDrive;
    res.drive_pattern = pat;
    res.last = 1'b1;
    return res;
  endfunction

  task automatic report_field(input string label, input logic [15:0] want,
                              input logic [15:0] got);
    if (want !== got)
      $display("%0t: %s expected %h, got %h", $time, label, want, got);
  endtask

  task automatic advance_scanner(input mkse_pkg::in_t item);
    logic [15:0]    port;
    logic [15:0]    m;
    logic [15:0]    colread;
    logic [7:0]     diff;
    int             rows;
    int             cols;
    int             p;
    mkse_pkg::out_t held;
    logic           have_held;
    rows = rows_active();
    cols = cols_active();
    port = item.port_value & mkse_pkg::PortMask;
    held = '0;
    have_held = 1'b0;
    if (ph == mkse_pkg::PH_COMPARE) begin
      // deferred comparison, events in row-major order
      for (int r = 0; r < rows; r++) begin
        diff = key_now[r] ^ key_seen[r];
        for (int c = 0; c < cols; c++) begin
          if (diff[c]) begin
            if (have_held) scan_output_q.push_back(held);
            held = '0;
            held.kind = mkse_pkg::KindEvent;
            held.drive_pattern = mkse_pkg::ZeroPattern;
            held.key_code = 6'(r * cols + c);
            held.pressed = key_now[r][c];
            have_held = 1'b1;
          end
        end
        key_seen[r] = key_now[r];
      end
      if (have_held) begin
        held.last = 1'b1;
        scan_output_q.push_back(held);
      end
      ticks = '0;
      ph = mkse_pkg::PH_IDLE;
    end else if (item.func == mkse_pkg::FuncTick) begin
      if (ticks != mkse_pkg::TickMax) ticks = ticks + 1'b1;
      if (ph == mkse_pkg::PH_IDLE && ticks > {1'b0, interval}) begin
        ph = mkse_pkg::PH_CHECK;
        scan_output_q.push_back(drive_result(check_pattern()));
      end
    end else if (ph == mkse_pkg::PH_CHECK) begin
      m = check_pattern();
      if ((port & m) == m) begin
        for (int r = 0; r < rows; r++) key_now[r] = '0;
        ph = mkse_pkg::PH_COMPARE;
        scan_output_q.push_back(drive_result(mkse_pkg::ReleasePattern));
      end else begin
        row_sel = ~port & m;
        col_at = '0;
        ph = mkse_pkg::PH_COL;
        scan_output_q.push_back(drive_result(col_pattern(3'd0)));
      end
    end else if (ph == mkse_pkg::PH_COL) begin
      colread = ~port & row_sel;
      for (int r = 0; r < rows; r++) begin
        p = int'(row_pins[4*r +: 4]);
        key_now[r][col_at] = (p < mkse_pkg::PortWidth) ? colread[p] : 1'b0;
      end
      if (int'(col_at) + 1 >= cols) begin
        col_at = '0;
        ph = mkse_pkg::PH_COMPARE;
        scan_output_q.push_back(drive_result(mkse_pkg::ReleasePattern));
      end else begin
        col_at = col_at + 1'b1;
        scan_output_q.push_back(drive_result(col_pattern(col_at)));
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    mkse_pkg::out_t want;
    if (!rst_ni) begin
      row_pins = RowPinsReset;
      col_pins = ColPinsReset;
      rows_cfg = 4'd4;
      cols_cfg = 4'd4;
      interval = 16'd10;
      ph = mkse_pkg::PH_IDLE;
      col_at = '0;
      row_sel = '0;
      ticks = '0;
      for (int r = 0; r < mkse_pkg::MaxRows; r++) begin
        key_now[r] = '0;
        key_seen[r] = '0;
      end
      scan_output_q.delete();
      errors = 0;
      pending_o <= 0;
      fail_count_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (scan_output_q.size() == 0) begin
          errors++;
          $display("%0t: result with nothing expected: kind %h drive %h key %h",
                   $time, out_data_i.kind, out_data_i.drive_pattern,
                   out_data_i.key_code);
          $display("%0t: result with nothing expected: pressed %h last %h",
                   $time, out_data_i.pressed, out_data_i.last);
        end else begin
          want = scan_output_q.pop_front();
          if (out_data_i !== want) begin
            errors++;
            report_field("kind", 16'(want.kind), 16'(out_data_i.kind));
            report_field("drive_pattern", want.drive_pattern, out_data_i.drive_pattern);
            report_field("key_code", 16'(want.key_code), 16'(out_data_i.key_code));
            report_field("pressed", 16'(want.pressed), 16'(out_data_i.pressed));
            report_field("last", 16'(want.last), 16'(out_data_i.last));
          end
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          mkse_pkg::CfgRowPinMap:    row_pins = cfg_wdata_i;
          mkse_pkg::CfgColPinMap:    col_pins = cfg_wdata_i;
          mkse_pkg::CfgNumRows:      rows_cfg = cfg_wdata_i[3:0];
          mkse_pkg::CfgNumCols:      cols_cfg = cfg_wdata_i[3:0];
          mkse_pkg::CfgScanInterval: interval = cfg_wdata_i[15:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) advance_scanner(in_data_i);
      pending_o <= scan_output_q.size();
      fail_count_o <= errors;
    end
  end

endmodule

@@ dv/matrix_keypad_scanner_events_core_tb.sv @@
// keypad scanner testbench top: clock, reset, keypad stimulus and verdict
`timescale 1ns / 100ps

module matrix_keypad_scanner_events_core_tb;

  localparam logic FuncPortRead = ~mkse_pkg::FuncTick;
  localparam int   SettleCycles = 300;
  localparam int   QuietLimit   = 2000;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  mkse_pkg::in_t                 in_data = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  mkse_pkg::out_t                out_data;
  logic                          cfg_we = 1'b0;
  logic [mkse_pkg::CfgIdxW-1:0]  cfg_idx = '0;
  logic [mkse_pkg::CfgDataW-1:0] cfg_wdata = '0;

  int                  pending;
  int                  fail_count;
  int                  gap_pct = 0;
  int                  stall_pct = 0;
  int                  quiet_cycles = 0;

  logic [15:0]         last_drive;
  logic [63:0]         held_keys = '0;
  logic [31:0]         key_row_pins = 32'h7654_3210;
  logic [31:0]         key_col_pins = 32'hFEDC_BA98;

  matrix_keypad_scanner_events_core u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  mkse_scan_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_data_i   (out_data),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_wdata_i  (cfg_wdata),
    .pending_o    (pending),
    .fail_count_o (fail_count)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      last_drive <= mkse_pkg::ReleasePattern;
    end else if (out_valid && out_ready && out_data.kind == mkse_pkg::KindDrive) begin
      last_drive <= out_data.drive_pattern;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic mkse_pkg::in_t mk_item(input logic f, input logic [15:0] port);
    mkse_pkg::in_t item;
    item.func = f;
    item.port_value = port;
    return item;
  endfunction

  // pressed keys pull the row and column pins together
  function automatic logic [15:0] port_reply();
    logic [15:0] levels;
    int rp;
    int cp;
    levels = last_drive;
    for (int r = 0; r < mkse_pkg::MaxRows; r++) begin
      for (int c = 0; c < mkse_pkg::MaxCols; c++) begin
        if (held_keys[r*mkse_pkg::MaxCols + c]) begin
          rp = int'(key_row_pins[4*r +: 4]);
          cp = int'(key_col_pins[4*c +: 4]);
          if (!last_drive[cp]) levels[rp] = 1'b0;
          if (!last_drive[rp]) levels[cp] = 1'b0;
        end
      end
    end
    return levels;
  endfunction

  task automatic offer(input mkse_pkg::in_t item);
    if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < gap_pct);
    end
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic wait_for_drive();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic wait_for_idle();
    wait_for_drive();
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_reg(input logic [mkse_pkg::CfgIdxW-1:0] idx,
                           input logic [mkse_pkg::CfgDataW-1:0] data);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  task automatic program_scanner(input logic [31:0] rmap, input logic [31:0] cmap,
                                 input logic [3:0] rows, input logic [3:0] cols,
                                 input logic [15:0] interval);
    key_row_pins = rmap;
    key_col_pins = cmap;
    write_reg(mkse_pkg::CfgRowPinMap, rmap);
    write_reg(mkse_pkg::CfgColPinMap, cmap);
    write_reg(mkse_pkg::CfgNumRows, {28'd0, rows});
    write_reg(mkse_pkg::CfgNumCols, {28'd0, cols});
    write_reg(mkse_pkg::CfgScanInterval, {16'd0, interval});
    cfg_we <= 1'b0;
  endtask

  task automatic run_phase(input int src_pct, input int snk_pct, input logic [31:0] rmap,
                           input logic [31:0] cmap, input logic [3:0] rows,
                           input logic [3:0] cols, input logic [15:0] interval,
                           input int lead_ticks, input int count);
    int roll;
    wait_for_idle();
    gap_pct = src_pct;
    stall_pct = snk_pct;
    program_scanner(rmap, cmap, rows, cols, interval);
    repeat (lead_ticks) offer(mk_item(mkse_pkg::FuncTick, 16'($urandom_range(65535))));
    for (int i = 0; i < count; i++) begin
      roll = $urandom_range(99);
      if (roll < 4) held_keys = '0;
      else if (roll < 7) held_keys = '1;
      else if (roll < 27) held_keys[$urandom_range(63)] = ~held_keys[$urandom_range(63)];
      roll = $urandom_range(99);
      if (roll < 40) begin
        offer(mk_item(mkse_pkg::FuncTick, 16'($urandom_range(65535))));
      end else if (roll < 85) begin
        wait_for_drive();
        offer(mk_item(FuncPortRead, port_reply()));
      end else if (roll < 93) begin
        wait_for_drive();
        offer(mk_item(FuncPortRead, port_reply() ^ (16'h1 << $urandom_range(15))));
      end else begin
        offer(mk_item(FuncPortRead, 16'($urandom_range(65535))));
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    program_scanner(32'h7654_3210, 32'hFEDC_BA98, 4'd4, 4'd4, 16'd1);

    // stray read while idle, then a scan that finds no key
    offer(mk_item(FuncPortRead, 16'hFFFF));
    offer(mk_item(mkse_pkg::FuncTick, 16'h0000));
    offer(mk_item(mkse_pkg::FuncTick, 16'hFFFF));
    offer(mk_item(FuncPortRead, 16'hFFFF));
    offer(mk_item(mkse_pkg::FuncTick, 16'h0000));
    // every key down, then every key up
    offer(mk_item(mkse_pkg::FuncTick, 16'h0000));
    offer(mk_item(mkse_pkg::FuncTick, 16'h0000));
    offer(mk_item(FuncPortRead, 16'h0000));
    repeat (4) offer(mk_item(FuncPortRead, 16'h0000));
    offer(mk_item(FuncPortRead, 16'hFFFF));
    offer(mk_item(mkse_pkg::FuncTick, 16'h0000));
    offer(mk_item(mkse_pkg::FuncTick, 16'h0000));
    offer(mk_item(FuncPortRead, 16'hFFFF));
    offer(mk_item(FuncPortRead, 16'h1234));
    // single key on row 2, with a tick transaction inside the scan
    offer(mk_item(mkse_pkg::FuncTick, 16'h0000));
    offer(mk_item(mkse_pkg::FuncTick, 16'h0000));
    offer(mk_item(FuncPortRead, 16'hFFFB));
    offer(mk_item(mkse_pkg::FuncTick, 16'hFFFF));
    offer(mk_item(FuncPortRead, 16'hFFFF));
    offer(mk_item(FuncPortRead, 16'hFFFB));
    offer(mk_item(FuncPortRead, 16'hFFFF));
    offer(mk_item(FuncPortRead, 16'hFFFF));
    offer(mk_item(mkse_pkg::FuncTick, 16'h0000));

    run_phase(0, 0, 32'h7654_3210, 32'hFEDC_BA98, 4'd8, 4'd8, 16'd0, 0, 100);
    run_phase(63, 0, $urandom, $urandom, 4'd1, 4'd1, 16'd3, 0, 100);
    run_phase(0, 63, $urandom, $urandom, 4'd0, 4'd15, 16'd2, 0, 100);
    run_phase(8, 8, 32'h0000_0000, 32'hFFFF_FFFF, 4'($urandom_range(15)),
              4'($urandom_range(15)), 16'($urandom_range(4)), 0, 100);
    run_phase(0, 0, 32'h0123_4567, 32'h89AB_CDEF, 4'd8, 4'd8, 16'd3, 4, 10);
    wait_for_idle();

    if (fail_count == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

@@ matrix_keypad_scanner_events_core.f @@
sv/mkse_pkg.sv
sv/mkse_seq.sv
sv/matrix_keypad_scanner_events.sv
dv/mkse_scan_checker.sv
dv/matrix_keypad_scanner_events_core_tb.sv
